// ----- rtl/triangle_gradient_frame_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef TRIANGLE_GRADIENT_FRAME_ASSERT_SVH
`define TRIANGLE_GRADIENT_FRAME_ASSERT_SVH
`ifndef ASSERT_OFF
`define TGF_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TGF_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TGF_ASSERT_RST(lbl, clk, rst, prop, msg)
`define TGF_ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/tgf_pkg.sv -----
package tgf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int TAG_W   = 20;
  localparam int DW      = 32;            // Q format word
  localparam int PW      = 2 * DW;        // product / cross magnitude
  localparam int SC_W    = DW - 1;        // normalized cross component
  localparam int SQ_W    = 2 * SC_W;
  localparam int ROOT_W  = DW;            // length of scaled normal
  localparam int QBITS   = DW + 2;        // quotient bits before rounding
  localparam int DIV_LAT = QBITS + 2;
  localparam int SH_W    = 7;
  localparam int EXP_W   = 8;
  localparam int LEN_W   = $clog2(PW + 1);
  localparam int SH_MIN  = 1 - SC_W;

  localparam int MAT_W       = 9 * DW;
  localparam int IN_BITS     = TAG_W + 9 * DW;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = TAG_W + MAT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAG_CAP = {1'b1, {(DW-1){1'b0}}};

  typedef logic [2:0][DW-1:0] vec3_t;
  typedef logic [2:0][PW-1:0] wvec3_t;

  function automatic logic [DW-1:0] sat_diff(input logic [DW-1:0] x, input logic [DW-1:0] y);
    logic [DW:0] d;
    d = {x[DW-1], x} - {y[DW-1], y};
    if (d[DW] != d[DW-1]) return d[DW] ? NEG_MIN : POS_MAX;
    return d[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] sgn_sat(input logic [DW-1:0] mag, input logic neg);
    if (neg) return -mag;
    return (mag > POS_MAX) ? POS_MAX : mag;
  endfunction

  function automatic logic [LEN_W-1:0] bit_len(input logic [PW-1:0] x);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < PW; i++) begin
      if (x[i]) n = LEN_W'(i + 1);
    end
    return n;
  endfunction

  function automatic int nxt(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  function automatic int prv(input int i);
    return (i == 0) ? 2 : i - 1;
  endfunction

endpackage

// ----- rtl/tgf_delay.sv -----
module tgf_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule

// ----- rtl/tgf_isqrt.sv -----
// One root bit per stage, MSB first.
module tgf_isqrt import tgf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [PW-1:0]     x,
  output logic [ROOT_W-1:0] root
);

  logic [PW-1:0]     rem_r [ROOT_W];
  logic [ROOT_W-1:0] rt_r  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_step
    localparam int B = ROOT_W - 1 - s;
    logic [PW-1:0]     rin;
    logic [ROOT_W-1:0] qin;
    logic [PW:0]       trial;

    if (s == 0) begin : g_first
      assign rin = x;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[s-1];
      assign qin = rt_r[s-1];
    end

    // (q + 2^B)^2 - q^2
    assign trial = ((PW+1)'(qin) << (B + 1)) + ((PW+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rin} >= trial) begin
          rem_r[s] <= PW'({1'b0, rin} - trial);
          rt_r[s]  <= qin | (ROOT_W'(1) << B);
        end else begin
          rem_r[s] <= rin;
          rt_r[s]  <= qin;
        end
      end
    end
  end

  assign root = rt_r[ROOT_W-1];

endmodule

// ----- rtl/tgf_div.sv -----
// mag = min(round(num * 2^(ex-1) / den), 2^31), restoring, one quotient bit per stage.
module tgf_div import tgf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [PW-1:0]           num,
  input  logic signed [EXP_W-1:0] ex,
  input  logic [ROOT_W-1:0]       den,
  output logic [DW-1:0]           mag
);

  localparam int EMAX = FRAC_BITS + 1 - SH_MIN;
  localparam int NW   = PW + EMAX;

  logic [EXP_W-1:0] amt;
  logic [NW-1:0]    wide;

  always_comb begin
    amt  = ex[EXP_W-1] ? EXP_W'(-ex) : EXP_W'(ex);
    wide = ex[EXP_W-1] ? (NW'(num) >> amt) : (NW'(num) << amt);
  end

  logic              ovf_r [QBITS+1];
  logic [ROOT_W-1:0] rem_r [QBITS+1];
  logic [ROOT_W-1:0] den_r [QBITS+1];
  logic [QBITS-1:0]  lo_r  [QBITS+1];
  logic [QBITS-1:0]  q_r   [QBITS+1];
  logic [DW-1:0]     mag_r;

  // quotient would not fit QBITS bits: result caps anyway
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= wide[NW-1:QBITS] >= (NW-QBITS)'(den);
      rem_r[0] <= wide[QBITS+ROOT_W-1:QBITS];
      lo_r[0]  <= wide[QBITS-1:0];
      den_r[0] <= den;
      q_r[0]   <= '0;
    end
  end

  for (genvar s = 1; s <= QBITS; s++) begin : g_step
    logic [ROOT_W:0] t;
    assign t = {rem_r[s-1], lo_r[s-1][QBITS-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[s] <= ovf_r[s-1];
        den_r[s] <= den_r[s-1];
        lo_r[s]  <= lo_r[s-1] << 1;
        if (t >= {1'b0, den_r[s-1]}) begin
          rem_r[s] <= ROOT_W'(t - {1'b0, den_r[s-1]});
          q_r[s]   <= {q_r[s-1][QBITS-2:0], 1'b1};
        end else begin
          rem_r[s] <= t[ROOT_W-1:0];
          q_r[s]   <= {q_r[s-1][QBITS-2:0], 1'b0};
        end
      end
    end
  end

  logic [QBITS:0]   qp;
  logic [QBITS-1:0] v;

  assign qp = {1'b0, q_r[QBITS]} + (QBITS+1)'(1);
  assign v  = qp[QBITS:1];

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= (ovf_r[QBITS] || v > QBITS'(MAG_CAP)) ? MAG_CAP : v[DW-1:0];
    end
  end

  assign mag = mag_r;

endmodule

// ----- rtl/triangle_gradient_frame.sv -----
// Pipeline: a 32-stage square root, two 36-stage dividers and 12 stages of edges,
//   products and rounding lie between input beat and output beat.
// Throughput: one triangle per cycle; a stall at the output holds every stage.
// Reset (rst, synchronous): empties the pipeline, invert returns to 1.
`include "triangle_gradient_frame_assert.svh"
module triangle_gradient_frame import tgf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // triangle_id, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // tag_out, m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [0:0]             m_tuser,   // degenerate
  input  logic                   cfg_wr_en,
  input  logic [0:0]             cfg_wr_data
);

  localparam int S_EDGE  = 1;
  localparam int S_CROSS = 3;
  localparam int S_BIG   = 4;
  localparam int S_SH    = 5;
  localparam int S_SC    = 6;
  localparam int S_SUM   = 8;
  localparam int S_ROOT  = S_SUM + ROOT_W;
  localparam int S_NRM   = S_ROOT + DIV_LAT;
  localparam int S_N     = S_NRM + 1;
  localparam int S_IABS  = S_N + 2;
  localparam int S_INV   = S_IABS + DIV_LAT;
  localparam int S_OUT   = S_INV + 1;
  localparam int N_LIMIT = 1 << FRAC_BITS;

  logic             adv;
  logic [S_OUT-1:0] vld;
  logic             invert;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[S_OUT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[S_OUT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      invert <= 1'b1;
    end else if (cfg_wr_en) begin
      invert <= cfg_wr_data[0];
    end
  end

  // edges
  logic [TAG_W-1:0] in_tag, tag1;
  vec3_t va, vb, vc, e1_1, e2_1;

  always_comb begin
    in_tag = s_tdata[TAG_W-1:0];
    for (int i = 0; i < 3; i++) begin
      va[i] = s_tdata[TAG_W + i*DW +: DW];
      vb[i] = s_tdata[TAG_W + (3+i)*DW +: DW];
      vc[i] = s_tdata[TAG_W + (6+i)*DW +: DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1 <= in_tag;
      for (int i = 0; i < 3; i++) begin
        e1_1[i] <= sat_diff(vb[i], va[i]);
        e2_1[i] <= sat_diff(vc[i], va[i]);
      end
    end
  end

  // cross product
  wvec3_t p2, q2, mag3, mag4, mag5;
  logic [2:0] neg3;
  logic signed [PW:0] cd [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p2[i] <= $signed(e1_1[nxt(i)]) * $signed(e2_1[prv(i)]);
        q2[i] <= $signed(e1_1[prv(i)]) * $signed(e2_1[nxt(i)]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cd[i] = $signed({p2[i][PW-1], p2[i]}) - $signed({q2[i][PW-1], q2[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= cd[i][PW];
        mag3[i] <= cd[i][PW] ? PW'(-cd[i]) : cd[i][PW-1:0];
      end
    end
  end

  // normalize to [2^30, 2^31)
  logic [PW-1:0] bigc, big4;
  logic          zero4;
  logic signed [SH_W-1:0] sh5;
  logic [2:0][SC_W-1:0] sc6;
  logic [2:0][SQ_W-1:0] sq7;
  logic [PW-1:0] sum8;

  always_comb begin
    bigc = mag3[0];
    if (mag3[1] > bigc) bigc = mag3[1];
    if (mag3[2] > bigc) bigc = mag3[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      big4  <= bigc;
      zero4 <= bigc == '0;
      mag4  <= mag3;
      sh5   <= SH_W'(int'(bit_len(big4)) - SC_W);
      mag5  <= mag4;
      for (int i = 0; i < 3; i++) begin
        sc6[i] <= sh5[SH_W-1] ? SC_W'(mag5[i] << SH_W'(-sh5)) : SC_W'(mag5[i] >> sh5);
        sq7[i] <= sc6[i] * sc6[i];
      end
      sum8 <= PW'(sq7[0]) + PW'(sq7[1]) + PW'(sq7[2]);
    end
  end

  logic [ROOT_W-1:0] root_l;

  tgf_isqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .x    (sum8),
    .root (root_l)
  );

  // unit normal
  logic [3*SC_W-1:0] sc_r;
  logic [2:0]        neg_n;
  vec3_t             nmag, n7;

  tgf_delay #(.WIDTH(3*SC_W), .DEPTH(S_ROOT - S_SC)) u_sc_dly (
    .clk (clk), .en (adv), .d (sc6), .q (sc_r)
  );

  tgf_delay #(.WIDTH(3), .DEPTH(S_NRM - S_CROSS)) u_neg_dly (
    .clk (clk), .en (adv), .d (neg3), .q (neg_n)
  );

  for (genvar i = 0; i < 3; i++) begin : g_nrm
    tgf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (adv),
      .num (PW'(sc_r[i*SC_W +: SC_W])),
      .ex  (EXP_W'(FRAC_BITS + 1)),
      .den (root_l),
      .mag (nmag[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) n7[i] <= neg_n[i] ? -nmag[i] : nmag[i];
    end
  end

  // inverse rows: (e2 x n) / det and (n x e1) / det
  logic [6*DW-1:0] e_n;
  vec3_t e1_n, e2_n;

  tgf_delay #(.WIDTH(6*DW), .DEPTH(S_N - S_EDGE)) u_e_dly (
    .clk (clk), .en (adv), .d ({e2_1, e1_1}), .q (e_n)
  );

  assign e1_n = e_n[3*DW-1:0];
  assign e2_n = e_n[6*DW-1:3*DW];

  wvec3_t pa0, pb0, pa1, pb1, imag0, imag1;
  logic [2:0] ineg0, ineg1;
  logic signed [PW:0] d0 [3];
  logic signed [PW:0] d1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        pa0[c] <= $signed(e2_n[nxt(c)]) * $signed(n7[prv(c)]);
        pb0[c] <= $signed(e2_n[prv(c)]) * $signed(n7[nxt(c)]);
        pa1[c] <= $signed(n7[nxt(c)]) * $signed(e1_n[prv(c)]);
        pb1[c] <= $signed(n7[prv(c)]) * $signed(e1_n[nxt(c)]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d0[c] = $signed({pa0[c][PW-1], pa0[c]}) - $signed({pb0[c][PW-1], pb0[c]});
      d1[c] = $signed({pa1[c][PW-1], pa1[c]}) - $signed({pb1[c][PW-1], pb1[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        ineg0[c] <= d0[c][PW];
        ineg1[c] <= d1[c][PW];
        imag0[c] <= d0[c][PW] ? PW'(-d0[c]) : d0[c][PW-1:0];
        imag1[c] <= d1[c][PW] ? PW'(-d1[c]) : d1[c][PW-1:0];
      end
    end
  end

  logic signed [SH_W-1:0]  sh_i;
  logic signed [EXP_W-1:0] ex_inv;
  logic [ROOT_W-1:0]       l_i;
  vec3_t                   imv0, imv1;

  tgf_delay #(.WIDTH(SH_W), .DEPTH(S_IABS - S_SH)) u_sh_dly (
    .clk (clk), .en (adv), .d (sh5), .q (sh_i)
  );

  tgf_delay #(.WIDTH(ROOT_W), .DEPTH(S_IABS - S_ROOT)) u_l_dly (
    .clk (clk), .en (adv), .d (root_l), .q (l_i)
  );

  assign ex_inv = EXP_W'(FRAC_BITS + 1) - EXP_W'(sh_i);

  for (genvar c = 0; c < 3; c++) begin : g_inv
    tgf_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
      .clk (clk), .en (adv), .num (imag0[c]), .ex (ex_inv), .den (l_i), .mag (imv0[c])
    );
    tgf_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
      .clk (clk), .en (adv), .num (imag1[c]), .ex (ex_inv), .den (l_i), .mag (imv1[c])
    );
  end

  // align side data with the inverse
  logic [9*DW-1:0]  fr_o;
  vec3_t            e1_o, e2_o, n_o;
  logic [5:0]       ineg_o;
  logic [TAG_W-1:0] tag_o;
  logic             zero_o;

  tgf_delay #(.WIDTH(9*DW), .DEPTH(S_INV - S_N)) u_fr_dly (
    .clk (clk), .en (adv), .d ({n7, e2_n, e1_n}), .q (fr_o)
  );

  assign e1_o = fr_o[3*DW-1:0];
  assign e2_o = fr_o[6*DW-1:3*DW];
  assign n_o  = fr_o[9*DW-1:6*DW];

  tgf_delay #(.WIDTH(6), .DEPTH(S_INV - S_IABS)) u_ineg_dly (
    .clk (clk), .en (adv), .d ({ineg1, ineg0}), .q (ineg_o)
  );

  tgf_delay #(.WIDTH(TAG_W), .DEPTH(S_INV - S_EDGE)) u_tag_dly (
    .clk (clk), .en (adv), .d (tag1), .q (tag_o)
  );

  tgf_delay #(.WIDTH(1), .DEPTH(S_INV - S_BIG)) u_zero_dly (
    .clk (clk), .en (adv), .d (zero4), .q (zero_o)
  );

  // output register
  logic [8:0][DW-1:0] mat;
  vec3_t              r0, r1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      r0[c] = sgn_sat(imv0[c], ineg_o[c]);
      r1[c] = sgn_sat(imv1[c], ineg_o[3+c]);
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (zero_o) begin
          mat[3*r+c] = '0;
        end else if (invert) begin
          mat[3*r+c] = (r == 0) ? r0[c] : (r == 1) ? r1[c] : n_o[c];
        end else begin
          mat[3*r+c] = (c == 0) ? e1_o[r] : (c == 1) ? e2_o[r] : n_o[r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= OUT_TDATA_W'({mat, tag_o});
      m_tuser <= zero_o;
    end
  end

  `TGF_ASSERT_RST(a_degen_zero, clk, rst, m_tvalid && m_tuser[0] |-> m_tdata[TAG_W +: MAT_W] == '0, "degenerate beat carries nonzero matrix")
  `TGF_ASSERT_RST(a_unit_normal, clk, rst, m_tvalid && !m_tuser[0] |-> ($signed(m_tdata[TAG_W + 8*DW +: DW]) <= N_LIMIT) && ($signed(m_tdata[TAG_W + 8*DW +: DW]) >= -N_LIMIT), "normal component above unit length")
  `TGF_ASSERT_RST(a_accept_enters, clk, rst, s_tvalid && s_tready |=> vld[0], "accepted beat missing from first stage")
  `TGF_ASSERT_CLK(a_reset_empty, clk, $past(rst) |-> !m_tvalid, "output valid right after reset")

endmodule

// ----- tb/tb_triangle_gradient_frame.sv -----
module tb_triangle_gradient_frame;
  import tgf_pkg::*;

  typedef struct {
    logic [TAG_W-1:0] tag;
    logic [8:0][DW-1:0] m;
    logic degen;
  } frame_res_t;

  typedef struct {
    logic [TAG_W-1:0] tag;
    logic [8:0][DW-1:0] v;   // a_x a_y a_z b_x b_y b_z c_x c_y c_z
    logic has_exp;
    logic [DW-1:0] m00;
    logic degen;
  } tri_row_t;

  localparam int LAT = 116;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_wr_en;
  logic [0:0] cfg_wr_data;

  frame_res_t frames_due[$];
  logic invert_mode;
  int n_err;
  int no_idle;        // when set, neither side idles
  int hold_sink;      // length of the next receiver hold-off, cleared once it is served
  tri_row_t rows[$];

  triangle_gradient_frame dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("** triangle_gradient_frame: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    n_err++;
  endtask

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else res >>= 1;
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] round_quot(input logic [63:0] a, input logic [63:0] l,
                                             input int k);
    logic [63:0] q, r;
    if (k < 0) q = (a * 2) / (l << (-k));
    else begin
      q = a / l;
      r = a % l;
      for (int i = 0; i <= k; i++) begin
        r <<= 1;
        q <<= 1;
        if (r >= l) begin
          r -= l;
          q |= 1;
        end
        if (q >= (64'd1 << 34)) break;
      end
    end
    q = (q + 1) >> 1;
    return (q > 64'h8000_0000) ? 64'h8000_0000 : q;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint signed_mag(input logic [63:0] mag, input logic neg);
    if (neg) return -longint'(mag);
    return (mag > 64'h7fff_ffff) ? 64'sd2147483647 : longint'(mag);
  endfunction

  function automatic frame_res_t predict_frame(input logic [TAG_W-1:0] tag,
                                               input logic [8:0][DW-1:0] v,
                                               input logic inv);
    frame_res_t f;
    longint e1[3], e2[3], nrm[3], p, q, p0, p1;
    logic [63:0] mag[3], sc[3], big, sum, len, u, a0, a1;
    logic neg[3];
    int sh, j, k;
    f.tag = tag;
    f.m = '0;
    f.degen = 0;
    big = 0;
    sum = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = clamp32(longint'($signed(v[3+i])) - longint'($signed(v[i])));
      e2[i] = clamp32(longint'($signed(v[6+i])) - longint'($signed(v[i])));
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      p = e1[j] * e2[k];
      q = e1[k] * e2[j];
      neg[i] = p < q;
      mag[i] = neg[i] ? 64'(q) - 64'(p) : 64'(p) - 64'(q);
      if (mag[i] > big) big = mag[i];
    end
    if (big == 0) begin
      f.degen = 1;
      return f;
    end
    while ((big >> sh) >= 64'h8000_0000) sh++;
    if (sh == 0)
      while ((big << (-sh)) < 64'h4000_0000) sh--;
    for (int i = 0; i < 3; i++) begin
      sc[i] = sh >= 0 ? mag[i] >> sh : mag[i] << (-sh);
      sum += sc[i] * sc[i];
    end
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      u = ((sc[i] << 17) / len + 1) >> 1;
      nrm[i] = neg[i] ? -longint'(u) : longint'(u);
    end
    for (int c = 0; c < 3; c++) begin
      j = (c + 1) % 3;
      k = (c + 2) % 3;
      if (inv) begin
        p0 = e2[j] * nrm[k] - e2[k] * nrm[j];
        p1 = nrm[j] * e1[k] - nrm[k] * e1[j];
        a0 = p0 < 0 ? 64'(-p0) : 64'(p0);
        a1 = p1 < 0 ? 64'(-p1) : 64'(p1);
        f.m[c]   = DW'(signed_mag(round_quot(a0, len, 16 - sh), p0 < 0));
        f.m[3+c] = DW'(signed_mag(round_quot(a1, len, 16 - sh), p1 < 0));
        f.m[6+c] = DW'(nrm[c]);
      end else begin
        f.m[3*c]   = DW'(e1[c]);
        f.m[3*c+1] = DW'(e2[c]);
        f.m[3*c+2] = DW'(nrm[c]);
      end
    end
    return f;
  endfunction

  function automatic logic [DW-1:0] rnd_coord(input int style);
    case (style)
      0: return $urandom;
      1: return DW'($signed($urandom_range(0, 40'h3ff_ffff)) - 32'sh01ff_ffff);
      2: return $urandom_range(0, 1) ? POS_MAX : NEG_MIN;
      default: return DW'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
    endcase
  endfunction

  // walks a row list, one beat per row; falling-edge drive
  task automatic send_rows(input int check_m00);
    tri_row_t r;
    while (rows.size() > 0) begin
      r = rows.pop_front();
      while (!no_idle && $urandom_range(0, 99) < 34) begin
        s_tvalid <= 0;
        @(negedge clk);
      end
      s_tvalid <= 1;
      s_tdata <= IN_TDATA_W'({r.v, r.tag});
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      frames_due.push_back(predict_frame(r.tag, r.v, invert_mode));
      if (check_m00 && r.has_exp) begin
        if (frames_due[$].m[0] !== r.m00)
          report_mismatch("table m00", frames_due[$].m[0], r.m00);
        if (frames_due[$].degen !== r.degen)
          report_mismatch("table degenerate", frames_due[$].degen, r.degen);
      end
      @(negedge clk);
    end
    s_tvalid <= 0;
    @(negedge clk);
  endtask

  task automatic drain;
    while (frames_due.size() > 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
  endtask

  task automatic write_mode(input logic val);
    cfg_wr_en <= 1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    invert_mode = val;
  endtask

  task automatic add_row(input logic [TAG_W-1:0] tag, input logic [8:0][DW-1:0] v,
                         input logic has_exp, input logic [DW-1:0] m00, input logic dg);
    tri_row_t r;
    r.tag = tag;
    r.v = v;
    r.has_exp = has_exp;
    r.m00 = m00;
    r.degen = dg;
    rows.push_back(r);
  endtask

  task automatic add_random(input int cnt);
    logic [8:0][DW-1:0] v;
    int style;
    for (int i = 0; i < cnt; i++) begin
      style = $urandom_range(0, 3);
      for (int c = 0; c < 9; c++) v[c] = rnd_coord($urandom_range(0, 9) == 0 ? 0 : style);
      if ($urandom_range(0, 19) == 0) v[6+:3] = v[3+:3];      // collinear / repeated vertex
      add_row(TAG_W'($urandom), v, 0, '0, 0);
    end
  endtask

  // receiver: random stalls, a long hold-off on request
  initial begin
    frame_res_t want;
    m_tready = 0;
    @(negedge clk);
    forever begin
      if (hold_sink > 0) begin
        m_tready <= 0;
        repeat (hold_sink) @(negedge clk);
        hold_sink = 0;
      end
      m_tready <= no_idle || ($urandom_range(0, 99) >= 34);
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (frames_due.size() == 0) report_mismatch("unexpected beat", m_tdata[63:0], 0);
        else begin
          want = frames_due.pop_front();
          if (m_tdata[TAG_W-1:0] !== want.tag)
            report_mismatch("tag_out", m_tdata[TAG_W-1:0], want.tag);
          for (int i = 0; i < 9; i++)
            if (m_tdata[TAG_W+DW*i +: DW] !== want.m[i])
              report_mismatch($sformatf("m%0d%0d", i / 3, i % 3),
                              m_tdata[TAG_W+DW*i +: DW], want.m[i]);
          if (m_tuser[0] !== want.degen) report_mismatch("degenerate", m_tuser, want.degen);
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    logic [8:0][DW-1:0] v;
    n_err = 0;
    no_idle = 0;
    hold_sink = 0;
    invert_mode = 1;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: degenerate cases, unit triangle, extremes
    add_row(20'h00000, '0, 1, '0, 1);
    v = '0;
    v[3] = 32'h0001_0000;
    v[7] = 32'h0001_0000;
    add_row(20'hfffff, v, 1, 32'h0001_0000, 0);        // inverse of identity
    add_row(20'h12345, {9{POS_MAX}}, 1, '0, 1);
    v = '0;
    v[3] = 32'h0002_0000;
    v[4] = 32'h0004_0000;
    add_row(20'h00001, v, 1, '0, 1);                   // collinear (c = a)
    v = '0;
    v[0] = NEG_MIN;
    v[3] = POS_MAX;
    v[7] = POS_MAX;
    add_row(20'h00002, v, 0, '0, 0);                   // saturated edges
    v = '0;
    v[3] = 32'h0000_0001;
    v[7] = 32'h0000_0001;
    add_row(20'h00003, v, 0, '0, 0);                   // tiny triangle, large inverse
    v = '0;
    v[3] = 32'hffff_0000;
    v[8] = 32'h0003_0000;
    add_row(20'h00004, v, 0, '0, 0);
    for (int i = 0; i < 6; i++) begin
      for (int c = 0; c < 9; c++) v[c] = rnd_coord(2);
      add_row(20'h00010 + i, v, 0, '0, 0);
    end
    send_rows(1);
    drain();

    write_mode(0);
    v = '0;
    v[3] = 32'h0001_0000;
    v[7] = 32'h0001_0000;
    add_row(20'h00020, v, 1, 32'h0001_0000, 0);
    add_row(20'h00021, {9{NEG_MIN}}, 1, '0, 1);
    v = '0;
    v[1] = NEG_MIN;
    v[3] = 32'hffff_ffff;
    v[8] = POS_MAX;
    add_row(20'h00022, v, 0, '0, 0);
    add_random(150);
    send_rows(1);
    // long receiver hold-off while the sender keeps offering
    hold_sink = 400;
    add_random(150);
    send_rows(0);
    drain();

    write_mode(1);
    no_idle = 1;
    add_random(100);
    send_rows(0);
    no_idle = 0;
    add_random(100);
    send_rows(0);
    drain();

    write_mode(0);
    add_random(50);
    send_rows(0);
    drain();
    write_mode(1);
    add_random(50);
    send_rows(0);
    drain();

    if (n_err == 0) $display("** triangle_gradient_frame: PASSED **");
    else $display("** triangle_gradient_frame: FAILED **");
    $finish;
  end
endmodule
